>>> rtl/svs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_pkg
// Payload types, codes and fixed widths shared by the sectioned voxel store.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int CELL_ID_W    = 15;
    localparam int COORD_W      = 4;
    localparam int HEIGHT_W     = 8;
    localparam int COUNT_W      = 13;
    localparam int MASK_W       = 16;
    localparam int FILLED_W     = 5;
    localparam int SECTION_LOG2 = 12;   // 16 x 16 x 16 cells per section

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [COORD_W-1:0]   x_pos;
        logic [HEIGHT_W-1:0]  y_pos;
        logic [COORD_W-1:0]   z_pos;
        logic [CELL_ID_W-1:0] new_id;
    } svs_in_t;

    typedef struct packed {
        logic [CELL_ID_W-1:0] read_id;
        logic [MASK_W-1:0]    section_mask;
        logic [FILLED_W-1:0]  filled_sections;
    } svs_out_t;

    // Section count update request
    typedef struct packed {
        logic en;
        logic inc;
        logic dec;
    } svs_upd_t;

endpackage

>>> rtl/svs_cell_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_cell_mem
// Single-write, single-read cell memory with registered read data and a
// zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module svs_cell_mem #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 15,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              busy
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [DATA_W-1:0] wd;

    // sweep zeros through the array while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        we = busy_reg | wr_en;
        wa = busy_reg ? clr_addr_reg : wr_addr;
        wd = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;
    assign busy    = busy_reg;

endmodule

>>> rtl/svs_section_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_section_track
// Per-section fill counts, a running count of occupied sections, and the
// occupancy mask as it stands after a pending update.
// ----------------------------------------------------------------------------
module svs_section_track #(
    parameter int SECTIONS = 16,
    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  svs_pkg::svs_upd_t             upd,
    input  logic [SEC_W-1:0]              sec,
    output logic [svs_pkg::MASK_W-1:0]    mask_after,
    output logic [svs_pkg::FILLED_W-1:0]  filled_after
);

    import svs_pkg::*;

    localparam int FW = $clog2(SECTIONS + 1);

    logic [COUNT_W-1:0] count_reg [SECTIONS];
    logic [FW-1:0]      filled_reg;
    logic [FW-1:0]      filled_next;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] cnt_next;
    logic               changing;
    logic               was_nz;
    logic               now_nz;
    logic [SECTIONS-1:0] nz_after;
    logic [31:0]        nz_ext;

    always_comb
    begin
        changing = upd.inc | upd.dec;
        cur      = count_reg[sec];
        if (upd.inc)
        begin
            cnt_next = cur + 1'b1;
        end
        else if (upd.dec)
        begin
            cnt_next = cur - 1'b1;
        end
        else
        begin
            cnt_next = cur;
        end
        was_nz = (cur != '0);
        now_nz = (cnt_next != '0);
        for (int i = 0; i < SECTIONS; i++)
        begin
            if (changing && (sec == SEC_W'(i)))
            begin
                nz_after[i] = now_nz;
            end
            else
            begin
                nz_after[i] = (count_reg[i] != '0);
            end
        end
        filled_next = filled_reg + FW'(changing && now_nz && !was_nz)
                                 - FW'(changing && was_nz && !now_nz);
        nz_ext       = 32'(nz_after);
        mask_after   = nz_ext[MASK_W-1:0];
        filled_after = FILLED_W'(filled_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SECTIONS; i++)
            begin
                count_reg[i] <= '0;
            end
            filled_reg <= '0;
        end
        else if (upd.en && changing)
        begin
            count_reg[sec] <= cnt_next;
            filled_reg     <= filled_next;
        end
    end

endmodule

>>> rtl/sectioned_voxel_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sectioned_voxel_store_top
// Chunk cell store with per-section fill tracking; one read-modify-write
// of a cell per transfer.
// ----------------------------------------------------------------------------
// After reset the block zeroes all SECTIONS * 4096 entries of its cell
// memory (65536 at the default), one entry per cycle, with in_ready low. From
// then on it takes one item per cycle while the output is not stalled: the
// cell is read from the single-port-write memory at acceptance; in stage 1
// the old value is checked, the new one written back for a write and the
// section count adjusted, the result landing in the output register. A write
// forwarded from the preceding item covers the case where two consecutive
// items touch the same cell. While a result waits on out_ready the item
// behind it holds in stage 1 and in_ready drops, so at most two items are in
// flight.
module sectioned_voxel_store_top #(
    parameter int SECTIONS = 16,
    parameter int ID_BITS  = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  svs_pkg::svs_in_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output svs_pkg::svs_out_t out_item
);

    import svs_pkg::*;

    localparam int DEPTH  = SECTIONS * (2 ** SECTION_LOG2);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    logic              busy;
    logic              accept;
    logic [ADDR_W-1:0] in_addr;
    logic [ID_BITS-1:0] rd_data;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    svs_in_t           s1_item_reg;
    logic              s1_go;
    logic [ADDR_W-1:0] s1_addr;
    logic              s1_in_range;
    logic [ID_BITS-1:0] s1_id;
    logic [ID_BITS-1:0] old_raw;
    logic [ID_BITS-1:0] old_id;
    logic              item_wr;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [ID_BITS-1:0] fwd_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    svs_out_t          out_item_reg;

    svs_upd_t          upd;
    logic [MASK_W-1:0] mask_after;
    logic [FILLED_W-1:0] filled_after;

    always_comb
    begin
        s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !busy && (!s1_valid_reg || s1_go);
        accept   = in_valid && in_ready;
        in_addr  = ADDR_W'({in_item.y_pos, in_item.z_pos, in_item.x_pos});
    end

    // stage 1: settle old value, write back, update section counts
    always_comb
    begin
        s1_addr     = ADDR_W'({s1_item_reg.y_pos, s1_item_reg.z_pos, s1_item_reg.x_pos});
        s1_in_range = (32'(s1_item_reg.y_pos[HEIGHT_W-1:COORD_W]) < SECTIONS);
        s1_id       = ID_BITS'(s1_item_reg.new_id);
        old_raw     = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : rd_data;
        old_id      = s1_in_range ? old_raw : '0;
        item_wr     = (s1_item_reg.operation == OP_WRITE) && s1_in_range;
        upd.en      = s1_go;
        upd.inc     = item_wr && (old_id == '0) && (s1_id != '0);
        upd.dec     = item_wr && (old_id != '0) && (s1_id == '0);
    end

    svs_cell_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (ID_BITS)
    ) u_cell_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (s1_go && item_wr),
        .wr_addr (s1_addr),
        .wr_data (s1_id),
        .busy    (busy)
    );

    svs_section_track #(
        .SECTIONS (SECTIONS)
    ) u_section_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (upd),
        .sec          (SEC_W'(s1_item_reg.y_pos[HEIGHT_W-1:COORD_W])),
        .mask_after   (mask_after),
        .filled_after (filled_after)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // hold the last write until the next item has resolved its read
            if (s1_go)
            begin
                fwd_valid_reg <= item_wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_go)
        begin
            fwd_addr_reg                 <= s1_addr;
            fwd_data_reg                 <= s1_id;
            out_item_reg.read_id         <= CELL_ID_W'(old_id);
            out_item_reg.section_mask    <= mask_after;
            out_item_reg.filled_sections <= filled_after;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !in_ready)
        else $error("item accepted during memory clear");

    a_no_item_write_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !(s1_go && item_wr))
        else $error("item write collides with memory clear");

    a_stalled_item_kept : assert property (
        @(posedge clk) disable iff (!rst_n) (s1_valid_reg && !s1_go) |=> s1_valid_reg)
        else $error("stalled item lost from stage 1");

    a_mask_matches_count : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (SECTIONS <= MASK_W)) |->
        ($countones(out_item_reg.section_mask) == 32'(out_item_reg.filled_sections)))
        else $error("section mask and filled count disagree");
`endif

endmodule
